// ===== design/room_object_list_manager_top_macros.svh =====
// assertion macros for the room object list manager
// used by room_object_list_manager_top; needs clk and rst_n in scope
`ifndef ROOM_OBJECT_LIST_MANAGER_TOP_MACROS_SVH
`define ROOM_OBJECT_LIST_MANAGER_TOP_MACROS_SVH

// same-cycle implication, skipped during reset
`define ROLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped during reset
`define ROLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rolm_pkg.sv =====
// shared constants, types and microprogram for the room object list manager
// no dependencies; used by rolm_useq, rolm_dpath and the top level
package rolm_pkg;

  localparam int OBJECT_SLOTS = 256;
  localparam int ROOM_SLOTS   = 256;
  localparam int ID_W         = 8;
  localparam int LIM_W        = ID_W + 1;
  localparam int OBJ_AW       = $clog2(OBJECT_SLOTS);
  localparam int ROOM_AW      = $clog2(ROOM_SLOTS);
  localparam int STEP_W       = $clog2(OBJECT_SLOTS + 1);
  localparam int CLR_N        = (OBJECT_SLOTS > ROOM_SLOTS) ? OBJECT_SLOTS : ROOM_SLOTS;
  localparam int CLR_W        = $clog2(CLR_N + 1);

  localparam logic [ID_W-1:0]  NONE_ID  = '1;
  localparam logic [LIM_W-1:0] OBJ_LIM  = LIM_W'(OBJECT_SLOTS);
  localparam logic [LIM_W-1:0] ROOM_LIM = LIM_W'(ROOM_SLOTS);

  localparam logic [1:0] CMD_MOVE = 2'd0;
  localparam logic [1:0] CMD_PAIR = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef logic [3:0] upc_t;

  localparam upc_t UP_IDLE  = 4'd0;
  localparam upc_t UP_OBJ   = 4'd1;
  localparam upc_t UP_HEAD  = 4'd2;
  localparam upc_t UP_WALK  = 4'd3;
  localparam upc_t UP_FIX   = 4'd4;
  localparam upc_t UP_SET   = 4'd5;
  localparam upc_t UP_PUSH  = 4'd6;
  localparam upc_t UP_NEXT  = 4'd7;
  localparam upc_t UP_DONE  = 4'd8;
  localparam upc_t UP_RD    = 4'd9;
  localparam upc_t UP_RDCAP = 4'd10;

  typedef enum logic [3:0] {
    A_NOP,
    A_RD_ROOM,
    A_HEAD,
    A_WALK,
    A_FIX,
    A_SET,
    A_PUSH,
    A_PAIR,
    A_DONE,
    A_RDCAP
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_START_RD,
    C_NO_START,
    C_OBJ_OOR,
    C_OLD_NONE,
    C_MISS,
    C_NOT_HIT,
    C_TGT_NONE,
    C_PAIR_MORE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t jcond;
    upc_t  target;
    cond_t hcond;
  } uword_t;

  typedef struct packed {
    logic clr_busy;
    logic obj_oor;
    logic old_none;
    logic miss;
    logic hit;
    logic tgt_none;
    logic pair_more;
  } stat_t;

  // jump when jcond holds, else stay when hcond holds, else fall through
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    unique case (pc)
      UP_IDLE:  w = '{A_NOP,     C_START_RD,  UP_RD,   C_NO_START};
      UP_OBJ:   w = '{A_RD_ROOM, C_OBJ_OOR,   UP_NEXT, C_NEVER};
      UP_HEAD:  w = '{A_HEAD,    C_OLD_NONE,  UP_SET,  C_NEVER};
      UP_WALK:  w = '{A_WALK,    C_MISS,      UP_SET,  C_NOT_HIT};
      UP_FIX:   w = '{A_FIX,     C_NEVER,     UP_IDLE, C_NEVER};
      UP_SET:   w = '{A_SET,     C_TGT_NONE,  UP_NEXT, C_NEVER};
      UP_PUSH:  w = '{A_PUSH,    C_NEVER,     UP_IDLE, C_NEVER};
      UP_NEXT:  w = '{A_PAIR,    C_PAIR_MORE, UP_OBJ,  C_NEVER};
      UP_DONE:  w = '{A_DONE,    C_OUT_FREE,  UP_IDLE, C_ALWAYS};
      UP_RD:    w = '{A_RD_ROOM, C_OBJ_OOR,   UP_DONE, C_NEVER};
      UP_RDCAP: w = '{A_RDCAP,   C_ALWAYS,    UP_DONE, C_NEVER};
      default:  w = '{A_NOP,     C_ALWAYS,    UP_IDLE, C_NEVER};
    endcase
    return w;
  endfunction

  function automatic logic obj_ok(input logic [ID_W-1:0] v);
    return {1'b0, v} < OBJ_LIM;
  endfunction

  function automatic logic room_ok(input logic [ID_W-1:0] v);
    return (v != NONE_ID) && ({1'b0, v} < ROOM_LIM);
  endfunction

endpackage

// ===== design/rolm_useq.sv =====
// microcode sequencer: step counter, control store lookup, branch logic
// depends on rolm_pkg
module rolm_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            start_rd,
  input  logic            out_free,
  input  rolm_pkg::stat_t stat,
  output rolm_pkg::act_t  act,
  output logic            idle
);

  rolm_pkg::upc_t   upc_r;
  rolm_pkg::upc_t   upc_nxt;
  rolm_pkg::uword_t uw;
  logic             jump;
  logic             hold;

  function automatic logic eval(input rolm_pkg::cond_t c, input rolm_pkg::stat_t s,
                                input logic st, input logic st_rd, input logic ofree);
    logic r;
    unique case (c)
      rolm_pkg::C_NEVER:     r = 1'b0;
      rolm_pkg::C_ALWAYS:    r = 1'b1;
      rolm_pkg::C_START_RD:  r = st && st_rd;
      rolm_pkg::C_NO_START:  r = !st;
      rolm_pkg::C_OBJ_OOR:   r = s.obj_oor;
      rolm_pkg::C_OLD_NONE:  r = s.old_none;
      rolm_pkg::C_MISS:      r = s.miss;
      rolm_pkg::C_NOT_HIT:   r = !s.hit;
      rolm_pkg::C_TGT_NONE:  r = s.tgt_none;
      rolm_pkg::C_PAIR_MORE: r = s.pair_more;
      rolm_pkg::C_OUT_FREE:  r = ofree;
      default:               r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    uw   = rolm_pkg::ucode(upc_r);
    jump = eval(uw.jcond, stat, start, start_rd, out_free);
    hold = eval(uw.hcond, stat, start, start_rd, out_free);
    priority if (jump) begin
      upc_nxt = uw.target;
    end else if (hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = 4'(upc_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= rolm_pkg::UP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign act  = uw.act;
  assign idle = (upc_r == rolm_pkg::UP_IDLE);

endmodule

// ===== design/rolm_dpath.sv =====
// datapath: head, link and room tables, list walker registers, result fields
// depends on rolm_pkg; driven by rolm_useq control words
module rolm_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [1:0]                 cmd,
  input  logic [rolm_pkg::ID_W-1:0]  object_id,
  input  logic [rolm_pkg::ID_W-1:0]  target_room,
  input  rolm_pkg::act_t             act,
  output rolm_pkg::stat_t            stat,
  output logic [rolm_pkg::ID_W-1:0]  previous_room,
  output logic [1:0]                 unlinked_count,
  output logic                       loop_detected
);

  logic [rolm_pkg::ID_W-1:0] head_mem [rolm_pkg::ROOM_SLOTS];
  logic [rolm_pkg::ID_W-1:0] link_mem [rolm_pkg::OBJECT_SLOTS];
  logic [rolm_pkg::ID_W-1:0] room_mem [rolm_pkg::OBJECT_SLOTS];

  logic [rolm_pkg::ID_W-1:0]   head_rd_r, link_rd_r, room_rd_r;
  logic [rolm_pkg::ID_W-1:0]   obj_r, tgt_r, old_r, trail_r, prev_room_r;
  logic                        pair_r, first_r, at_head_r, loop_r;
  logic [1:0]                  count_r;
  logic [rolm_pkg::STEP_W-1:0] steps_r;
  logic [rolm_pkg::CLR_W-1:0]  clr_cnt_r;

  logic                         clr_busy;
  logic [rolm_pkg::ID_W-1:0]    cur;
  logic [rolm_pkg::ID_W-1:0]    obj_odd;
  logic                         miss, hit;

  logic                         head_we, link_we, room_we;
  logic [rolm_pkg::ROOM_AW-1:0] head_wa;
  logic [rolm_pkg::OBJ_AW-1:0]  link_wa, room_wa;
  logic [rolm_pkg::ID_W-1:0]    head_wd, link_wd, room_wd;
  logic                         head_re, link_re, room_re;
  logic [rolm_pkg::ROOM_AW-1:0] head_ra;
  logic [rolm_pkg::OBJ_AW-1:0]  link_ra, room_ra;

  assign clr_busy = (clr_cnt_r != rolm_pkg::CLR_W'(rolm_pkg::CLR_N));
  assign cur      = at_head_r ? head_rd_r : link_rd_r;
  assign obj_odd  = obj_r | rolm_pkg::ID_W'(1);
  // a walk longer than the table size can only be circling
  assign miss     = (cur == rolm_pkg::NONE_ID) ||
                    (steps_r == rolm_pkg::STEP_W'(rolm_pkg::OBJECT_SLOTS));
  assign hit      = (cur == obj_r);

  always_comb begin
    stat.clr_busy  = clr_busy;
    stat.obj_oor   = !rolm_pkg::obj_ok(obj_r);
    stat.old_none  = !rolm_pkg::room_ok(room_rd_r);
    stat.miss      = miss;
    stat.hit       = hit;
    stat.tgt_none  = (tgt_r == rolm_pkg::NONE_ID);
    stat.pair_more = pair_r && first_r && rolm_pkg::obj_ok(obj_odd);
  end

  // table ports
  always_comb begin
    head_we = 1'b0;
    link_we = 1'b0;
    room_we = 1'b0;
    head_wa = old_r[rolm_pkg::ROOM_AW-1:0];
    link_wa = trail_r[rolm_pkg::OBJ_AW-1:0];
    room_wa = obj_r[rolm_pkg::OBJ_AW-1:0];
    head_wd = link_rd_r;
    link_wd = link_rd_r;
    room_wd = tgt_r;
    head_re = 1'b0;
    link_re = 1'b0;
    room_re = 1'b0;
    head_ra = room_rd_r[rolm_pkg::ROOM_AW-1:0];
    link_ra = cur[rolm_pkg::OBJ_AW-1:0];
    room_ra = obj_r[rolm_pkg::OBJ_AW-1:0];
    if (clr_busy) begin
      head_we = clr_cnt_r < rolm_pkg::CLR_W'(rolm_pkg::ROOM_SLOTS);
      link_we = clr_cnt_r < rolm_pkg::CLR_W'(rolm_pkg::OBJECT_SLOTS);
      room_we = link_we;
      head_wa = clr_cnt_r[rolm_pkg::ROOM_AW-1:0];
      link_wa = clr_cnt_r[rolm_pkg::OBJ_AW-1:0];
      room_wa = clr_cnt_r[rolm_pkg::OBJ_AW-1:0];
      head_wd = rolm_pkg::NONE_ID;
      link_wd = rolm_pkg::NONE_ID;
      room_wd = rolm_pkg::NONE_ID;
    end else begin
      unique case (act)
        rolm_pkg::A_RD_ROOM: room_re = 1'b1;
        rolm_pkg::A_HEAD:    head_re = 1'b1;
        rolm_pkg::A_WALK:    link_re = 1'b1;
        rolm_pkg::A_FIX: begin
          head_we = at_head_r;
          link_we = !at_head_r;
        end
        rolm_pkg::A_SET: begin
          room_we = 1'b1;
          head_re = 1'b1;
          head_ra = tgt_r[rolm_pkg::ROOM_AW-1:0];
        end
        rolm_pkg::A_PUSH: begin
          head_we = 1'b1;
          head_wa = tgt_r[rolm_pkg::ROOM_AW-1:0];
          head_wd = obj_r;
          link_we = 1'b1;
          link_wa = obj_r[rolm_pkg::OBJ_AW-1:0];
          link_wd = head_rd_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (room_we) begin
      room_mem[room_wa] <= room_wd;
    end
    if (head_re) begin
      head_rd_r <= head_mem[head_ra];
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_ra];
    end
    if (room_re) begin
      room_rd_r <= room_mem[room_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clr_busy) begin
      clr_cnt_r <= rolm_pkg::CLR_W'(clr_cnt_r + 1'b1);
    end
  end

  // walker and result registers
  always_ff @(posedge clk) begin
    if (start) begin
      obj_r       <= (cmd == rolm_pkg::CMD_PAIR) ? {object_id[rolm_pkg::ID_W-1:1], 1'b0}
                                                 : object_id;
      tgt_r       <= rolm_pkg::room_ok(target_room) ? target_room : rolm_pkg::NONE_ID;
      pair_r      <= (cmd == rolm_pkg::CMD_PAIR);
      first_r     <= 1'b1;
      prev_room_r <= rolm_pkg::NONE_ID;
      count_r     <= '0;
      loop_r      <= 1'b0;
    end else begin
      unique case (act)
        rolm_pkg::A_HEAD: begin
          old_r     <= room_rd_r;
          at_head_r <= 1'b1;
          steps_r   <= '0;
          if (first_r) begin
            prev_room_r <= room_rd_r;
          end
        end
        rolm_pkg::A_WALK: begin
          if (miss && (cur != rolm_pkg::NONE_ID)) begin
            loop_r <= 1'b1;
          end
          if (!miss && !hit) begin
            trail_r   <= cur;
            at_head_r <= 1'b0;
            steps_r   <= rolm_pkg::STEP_W'(steps_r + 1'b1);
          end
        end
        rolm_pkg::A_FIX:   count_r <= 2'(count_r + 2'd1);
        rolm_pkg::A_PAIR: begin
          if (stat.pair_more) begin
            obj_r   <= obj_odd;
            first_r <= 1'b0;
          end
        end
        rolm_pkg::A_RDCAP: prev_room_r <= room_rd_r;
        default: ;
      endcase
    end
  end

  assign previous_room  = prev_room_r;
  assign unlinked_count = count_r;
  assign loop_detected  = loop_r;

endmodule

// ===== design/room_object_list_manager_top.sv =====
// top level of the room object list manager: input handshake, result register
// depends on rolm_pkg, rolm_useq, rolm_dpath and room_object_list_manager_top_macros.svh
//
//  channel | ports                                              | direction
//  in      | in_valid in_stall in_cmd in_object_id in_target_room | command beat in
//  out     | out_valid out_stall out_previous_room                | result beat out
//          |   out_unlinked_count out_loop_detected               |
//
// one command at a time; a move walks at most OBJECT_SLOTS+1 entries of the old
// room's list, a pair move up to twice that, a read none
// the walk steps once per cycle through the link table read port
// after reset a clearing pass fills all tables with none; no beat
// is taken meanwhile
// a result waiting under out_stall does not block the next command beat
`include "room_object_list_manager_top_macros.svh"

module room_object_list_manager_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [rolm_pkg::ID_W-1:0] in_object_id,
  input  logic [rolm_pkg::ID_W-1:0] in_target_room,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rolm_pkg::ID_W-1:0] out_previous_room,
  output logic [1:0]                out_unlinked_count,
  output logic                      out_loop_detected
);

  rolm_pkg::stat_t           stat;
  rolm_pkg::act_t            act;
  logic                      idle;
  logic                      start, start_rd, out_free, load;
  logic [rolm_pkg::ID_W-1:0] dp_prev;
  logic [1:0]                dp_count;
  logic                      dp_loop;

  logic                      out_valid_r, out_valid_nxt;
  logic [rolm_pkg::ID_W-1:0] out_prev_r;
  logic [1:0]                out_count_r;
  logic                      out_loop_r;

  assign in_stall = !idle || stat.clr_busy;
  assign start    = in_valid && !in_stall;
  assign start_rd = (in_cmd != rolm_pkg::CMD_MOVE) && (in_cmd != rolm_pkg::CMD_PAIR);
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (act == rolm_pkg::A_DONE) && out_free;

  rolm_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .start_rd (start_rd),
    .out_free (out_free),
    .stat     (stat),
    .act      (act),
    .idle     (idle)
  );

  rolm_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .cmd            (in_cmd),
    .object_id      (in_object_id),
    .target_room    (in_target_room),
    .act            (act),
    .stat           (stat),
    .previous_room  (dp_prev),
    .unlinked_count (dp_count),
    .loop_detected  (dp_loop)
  );

  always_comb begin
    priority if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_prev_r  <= dp_prev;
      out_count_r <= dp_count;
      out_loop_r  <= dp_loop;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_previous_room  = out_prev_r;
  assign out_unlinked_count = out_count_r;
  assign out_loop_detected  = out_loop_r;

  `ROLM_ASSERT_NXT(a_busy_after_beat, start, in_stall, "sequencer idle right after a command beat")
  `ROLM_ASSERT_IMP(a_idle_while_clear, stat.clr_busy, idle, "sequencer active during clearing pass")
  `ROLM_ASSERT_IMP(a_count_range, act == rolm_pkg::A_DONE, dp_count != 2'd3, "unlink count overflow")

endmodule
